// ===== rtl/core/efr_pkg.sv =====
// Shared constants for the escaped frame receiver: default store size, framing
// bytes, checksum target and result status codes. No dependencies.
`default_nettype none

package efr_pkg;

    localparam int unsigned STORE_BYTES_DEFAULT = 64;

    localparam logic [7:0] START_BYTE = 8'h7E;
    localparam logic [7:0] ESC_BYTE   = 8'h7D;
    localparam logic [7:0] ESC_XOR    = 8'h20;
    localparam logic [7:0] SUM_GOOD   = 8'hFF;

    typedef logic [1:0] status_t;

    localparam status_t STATUS_DATA     = 2'd0;
    localparam status_t STATUS_CHECKSUM = 2'd1;
    localparam status_t STATUS_OVERSIZE = 2'd2;

endpackage

`default_nettype wire

// ===== rtl/core/escaped_frame_receiver_top.sv =====
// Escaped frame receiver: deframes, unescapes and checksums serial bytes.
// Depends on efr_pkg for framing constants and status codes.
`default_nettype none

// Input stalls while the output is stalled. A 0x7E byte starts a frame, 0x7D
// escapes the next byte (XOR 0x20), two length bytes follow (high byte first),
// then the data bytes and a checksum byte. Data bytes go into a frame store
// of STORE_BYTES entries. When the checksum byte arrives and the running sum
// is 0xFF, the data bytes are read back out of the store through its single,
// registered read port; a new read is issued only when no earlier read is
// pending and the output register is free, and no input is taken during
// that readout. A bad checksum, or a length above STORE_BYTES - 4, gives a
// single error transfer with tlast set.
module escaped_frame_receiver_top
    import efr_pkg::*;
#(
    parameter int unsigned STORE_BYTES = STORE_BYTES_DEFAULT
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       s_axis_tvalid,
    output logic            s_axis_tready,
    input  wire logic [7:0] s_axis_tdata,   // [7:0] rx_byte
    output logic            m_axis_tvalid,
    input  wire logic       m_axis_tready,
    output logic [7:0]      m_axis_tdata,   // [7:0] data_byte
    output logic            m_axis_tlast,   // last_byte
    output logic [1:0]      m_axis_tuser    // [1:0] status
);

    localparam int unsigned AW  = $clog2(STORE_BYTES);
    localparam int unsigned WPW = $clog2(STORE_BYTES + 1);
    localparam int unsigned LW  = $clog2(STORE_BYTES - 3);
    localparam logic [15:0] LEN_MAX = 16'(STORE_BYTES - 4);

    localparam logic ST_RX    = 1'b0;
    localparam logic ST_DRAIN = 1'b1;

    logic [7:0]     mem [STORE_BYTES];
    logic [7:0]     rdata_reg;

    logic           state_reg, state_next;
    logic [WPW-1:0] wp_reg, wp_next;
    logic           esc_reg, esc_next;
    logic [7:0]     len_hi_reg, len_hi_next;
    logic [LW-1:0]  len_reg, len_next;
    logic [7:0]     sum_reg, sum_next;
    logic [AW-1:0]  rd_addr_reg, rd_addr_next;
    logic           pend_reg, pend_next;
    logic           pend_last_reg, pend_last_next;

    logic           out_valid_reg, out_valid_next;
    logic [7:0]     out_data_reg, out_data_next;
    logic           out_last_reg, out_last_next;
    status_t        out_status_reg, out_status_next;

    logic           out_free;
    logic           in_fire;
    logic [7:0]     b;
    logic [15:0]    len16;
    logic           mem_we;
    logic           rd_issue;
    logic           rd_last;

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = (state_reg == ST_RX) && out_free && !pend_reg;
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign b             = esc_reg ? (s_axis_tdata ^ ESC_XOR) : s_axis_tdata;
    assign len16         = {len_hi_reg, b};
    assign rd_issue      = (state_reg == ST_DRAIN) && !pend_reg && out_free;
    assign rd_last       = rd_addr_reg == (AW'(len_reg) + AW'(2));

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tuser  = out_status_reg;

    always_comb
    begin
        state_next      = state_reg;
        wp_next         = wp_reg;
        esc_next        = esc_reg;
        len_hi_next     = len_hi_reg;
        len_next        = len_reg;
        sum_next        = sum_reg;
        rd_addr_next    = rd_addr_reg;
        pend_next       = 1'b0;
        pend_last_next  = pend_last_reg;
        out_valid_next  = out_valid_reg && !m_axis_tready;
        out_data_next   = out_data_reg;
        out_last_next   = out_last_reg;
        out_status_next = out_status_reg;
        mem_we          = 1'b0;

        if (in_fire) begin
            priority if (s_axis_tdata == START_BYTE)
            begin
                wp_next  = WPW'(1);
                esc_next = 1'b0;
            end
            else if (wp_reg == '0)
            begin
                // Outside a frame: ignored.
            end
            else if (s_axis_tdata == ESC_BYTE)
            begin
                esc_next = 1'b1;
            end
            else if (wp_reg == WPW'(1))
            begin
                esc_next    = 1'b0;
                len_hi_next = b;
                wp_next     = WPW'(2);
            end
            else if (wp_reg == WPW'(2))
            begin
                esc_next = 1'b0;
                sum_next = '0;
                if (len16 > LEN_MAX)
                begin
                    out_valid_next  = 1'b1;
                    out_data_next   = '0;
                    out_last_next   = 1'b1;
                    out_status_next = STATUS_OVERSIZE;
                    wp_next         = '0;
                end
                else
                begin
                    len_next = LW'(len16);
                    wp_next  = WPW'(3);
                end
            end
            else if (wp_reg == (WPW'(len_reg) + WPW'(3)))
            begin
                // Checksum byte closes the frame.
                esc_next = 1'b0;
                wp_next  = '0;
                if (8'(sum_reg + b) != SUM_GOOD)
                begin
                    out_valid_next  = 1'b1;
                    out_data_next   = '0;
                    out_last_next   = 1'b1;
                    out_status_next = STATUS_CHECKSUM;
                end
                else if (len_reg != '0)
                begin
                    state_next   = ST_DRAIN;
                    rd_addr_next = AW'(3);
                end
            end
            else
            begin
                esc_next = 1'b0;
                mem_we   = 1'b1;
                sum_next = 8'(sum_reg + b);
                wp_next  = WPW'(wp_reg + WPW'(1));
            end
        end

        if (rd_issue) begin
            pend_next      = 1'b1;
            pend_last_next = rd_last;
            rd_addr_next   = AW'(rd_addr_reg + AW'(1));
            if (rd_last)
            begin
                state_next = ST_RX;
            end
        end

        // The read issued last cycle lands in a free output register.
        if (pend_reg) begin
            out_valid_next  = 1'b1;
            out_data_next   = rdata_reg;
            out_last_next   = pend_last_reg;
            out_status_next = STATUS_DATA;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[wp_reg[AW-1:0]] <= b;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_issue)
        begin
            rdata_reg <= mem[rd_addr_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        len_hi_reg     <= len_hi_next;
        len_reg        <= len_next;
        sum_reg        <= sum_next;
        rd_addr_reg    <= rd_addr_next;
        pend_last_reg  <= pend_last_next;
        out_data_reg   <= out_data_next;
        out_last_reg   <= out_last_next;
        out_status_reg <= out_status_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_RX;
            wp_reg        <= '0;
            esc_reg       <= 1'b0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            wp_reg        <= wp_next;
            esc_reg       <= esc_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

// ===== tb/escaped_frame_receiver_top_tb.sv =====
// Self-checking testbench for escaped_frame_receiver_top: sends framed, escaped
// serial bytes and checks every output transfer against a built-in deframer.
// Depends on efr_pkg and the receiver RTL.
`default_nettype none

module escaped_frame_receiver_top_tb;
    import efr_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned STORE_BYTES = STORE_BYTES_DEFAULT;
    localparam int unsigned MAX_LEN     = STORE_BYTES - 4;
    localparam int          QUIET_LIMIT = 2000;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        status_t    status;
    } frame_result_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata = 8'h00;
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;
    logic       m_axis_tlast;
    logic [1:0] m_axis_tuser;

    // Bytes waiting to be sent and results the deframer predicts.
    logic [7:0]    pending_bytes[$];
    frame_result_t expected_results[$];

    // Deframer state.
    logic [7:0]  rx_store [STORE_BYTES];
    int unsigned rx_pos = 0;
    logic [15:0] rx_len = 16'h0000;
    bit          rx_esc = 1'b0;

    bit            calm = 1'b0;
    bit            byte_taken = 1'b0;
    bit            active;
    int            send_gap = 0;
    int            hold_left = 0;
    int            quiet_cycles = 0;
    int            mismatches = 0;
    int            framed_bytes = 0;
    frame_result_t got;
    frame_result_t want;

    escaped_frame_receiver_top #(.STORE_BYTES(STORE_BYTES)) uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #4 clk = ~clk;

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        mismatches++;
    endtask

    task automatic push_result(input logic [7:0] data, input logic last, input status_t status);
        frame_result_t r;
        r.data = data;
        r.last = last;
        r.status = status;
        expected_results.push_back(r);
    endtask

    // Advances the deframer by one received byte and queues what it emits.
    task automatic deframe_byte(input logic [7:0] raw);
        logic [7:0]  b;
        logic [7:0]  sum;
        int unsigned frame_end;
        b = raw;
        if (b == START_BYTE) begin
            rx_store[0] = START_BYTE;
            rx_pos = 1;
            rx_esc = 1'b0;
            return;
        end
        if (rx_pos == 0)
            return;
        if (b == ESC_BYTE) begin
            rx_esc = 1'b1;
            return;
        end
        if (rx_esc)
            b = b ^ ESC_XOR;
        rx_esc = 1'b0;
        if (rx_pos < STORE_BYTES)
            rx_store[rx_pos] = b;
        if (rx_pos == 1) begin
            rx_len = {b, 8'h00};
        end
        else if (rx_pos == 2) begin
            rx_len[7:0] = b;
            if (int'(rx_len) + 4 > STORE_BYTES) begin
                push_result(8'h00, 1'b1, STATUS_OVERSIZE);
                rx_pos = 0;
                return;
            end
        end
        rx_pos++;
        frame_end = int'(rx_len) + 4;
        if (rx_pos >= 3 && rx_pos >= frame_end) begin
            sum = 8'h00;
            for (int i = 3; i < frame_end; i++)
                sum = sum + rx_store[i];
            if (sum != SUM_GOOD) begin
                push_result(8'h00, 1'b1, STATUS_CHECKSUM);
            end
            else begin
                for (int i = 0; i < rx_len; i++)
                    push_result(rx_store[3 + i], (i + 1 == rx_len), STATUS_DATA);
            end
            rx_pos = 0;
        end
    endtask

    // Sends one logical byte, escaping it when it collides with a framing
    // byte and now and then when it does not. An escape is sometimes doubled.
    task automatic push_symbol(input logic [7:0] v);
        bit esc_it;
        esc_it = (v == START_BYTE) || (v == ESC_BYTE) ||
                 ((v != (START_BYTE ^ ESC_XOR)) && (v != (ESC_BYTE ^ ESC_XOR)) &&
                  ($urandom_range(0, 15) == 0));
        if (esc_it) begin
            if ($urandom_range(0, 7) == 0) begin
                pending_bytes.push_back(ESC_BYTE);
                framed_bytes++;
            end
            pending_bytes.push_back(ESC_BYTE);
            pending_bytes.push_back(v ^ ESC_XOR);
            framed_bytes += 2;
        end
        else begin
            pending_bytes.push_back(v);
            framed_bytes++;
        end
    endtask

    // Builds a frame of len data bytes. keep >= 0 cuts it after that many
    // logical bytes so that the next start byte interrupts it.
    task automatic send_frame(input int unsigned len, input bit bad_sum, input int keep);
        logic [7:0]  body[$];
        logic [7:0]  acc;
        logic [7:0]  d;
        logic [15:0] len16;
        len16 = len[15:0];
        body.push_back(len16[15:8]);
        body.push_back(len16[7:0]);
        acc = 8'h00;
        if (len <= MAX_LEN) begin
            for (int i = 0; i < len; i++) begin
                d = 8'($urandom_range(0, 255));
                body.push_back(d);
                acc = acc + d;
            end
            d = SUM_GOOD - acc;
            if (bad_sum)
                d = d + 8'($urandom_range(1, 255));
            body.push_back(d);
        end
        if (keep >= 0) begin
            while (body.size() > keep)
                void'(body.pop_back());
        end
        pending_bytes.push_back(START_BYTE);
        framed_bytes++;
        foreach (body[i])
            push_symbol(body[i]);
    endtask

    task automatic random_frame();
        int unsigned pick;
        int unsigned len;
        logic [7:0]  v;
        pick = $urandom_range(0, 99);
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(30, MAX_LEN) : $urandom_range(0, 8);
        if (pick < 55) begin
            send_frame(len, 1'b0, -1);
        end
        else if (pick < 70) begin
            send_frame(len, 1'b1, -1);
        end
        else if (pick < 80) begin
            len = ($urandom_range(0, 3) == 0) ? MAX_LEN + 1 : $urandom_range(MAX_LEN + 1, 65535);
            send_frame(len, 1'b0, -1);
        end
        else begin
            send_frame(len, 1'b0, $urandom_range(0, len + 2));
        end
        // Line noise between complete frames is ignored by the receiver.
        if (pick < 80 && $urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(1, 4)) begin
                v = 8'($urandom_range(0, 255));
                if (v == START_BYTE)
                    v = 8'h00;
                pending_bytes.push_back(v);
                framed_bytes++;
            end
        end
    endtask

    task automatic drain();
        do
            @(negedge clk);
        while (pending_bytes.size() != 0 || expected_results.size() != 0);
        @(posedge clk);
    endtask

    // Byte driver: holds a transfer until it is taken, with random gaps.
    always @(negedge clk) begin
        if (!rst_n) begin
            s_axis_tvalid <= 1'b0;
        end
        else if (!s_axis_tvalid || byte_taken) begin
            byte_taken = 1'b0;
            if (send_gap > 0) begin
                send_gap--;
                s_axis_tvalid <= 1'b0;
            end
            else if (!calm && pending_bytes.size() != 0 && $urandom_range(0, 5) == 0) begin
                send_gap = $urandom_range(0, 18);
                s_axis_tvalid <= 1'b0;
            end
            else if (pending_bytes.size() != 0) begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata <= pending_bytes[0];
            end
            else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Result sink with random stall bursts.
    always @(negedge clk) begin
        if (!rst_n) begin
            m_axis_tready <= 1'b0;
        end
        else if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end
        else if (!calm && $urandom_range(0, 7) == 0) begin
            hold_left = $urandom_range(0, 18);
            m_axis_tready <= 1'b0;
        end
        else begin
            m_axis_tready <= 1'b1;
        end
    end

    // Monitor: predicts on each input transfer, checks each output transfer.
    always @(posedge clk) begin
        if (rst_n) begin
            active = 1'b0;
            if (s_axis_tvalid && s_axis_tready) begin
                deframe_byte(s_axis_tdata);
                pending_bytes.delete(0);
                byte_taken = 1'b1;
                active = 1'b1;
            end
            if (m_axis_tvalid && m_axis_tready) begin
                active = 1'b1;
                got = {m_axis_tdata, m_axis_tlast, m_axis_tuser};
                if (expected_results.size() == 0) begin
                    report_mismatch($sformatf("unexpected result data=%02h last=%0b status=%0d",
                                              got.data, got.last, got.status));
                end
                else begin
                    want = expected_results.pop_front();
                    if (got != want)
                        report_mismatch($sformatf(
                            "data=%02h last=%0b status=%0d, expected %02h %0b %0d",
                            got.data, got.last, got.status,
                            want.data, want.last, want.status));
                end
            end
            quiet_cycles = active ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    initial begin
        logic [7:0] directed[$];
        // Noise, good empty frame, restart over a pending escape into an empty
        // frame with a bad checksum, smallest oversized length, then a frame
        // with an escaped length byte, a double escape and a 0xFF data byte.
        directed = {8'hFF,
                    8'h7E, 8'h00, 8'h00, 8'hFF,
                    8'h7E, 8'h00, 8'h7D, 8'h7E, 8'h00, 8'h00, 8'h00,
                    8'h7E, 8'h00, 8'h3D,
                    8'h7E, 8'h7D, 8'h20, 8'h02, 8'h7D, 8'h7D, 8'h5E, 8'hFF, 8'h82};
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(posedge clk);
        foreach (directed[i])
            pending_bytes.push_back(directed[i]);
        framed_bytes += directed.size();
        drain();

        send_frame(MAX_LEN, 1'b0, -1);
        send_frame(16'hFFFF, 1'b0, -1);
        while (framed_bytes < 95)
            random_frame();
        drain();

        // Final stretch runs at full rate on both sides.
        calm = 1'b1;
        while (framed_bytes < 115)
            random_frame();
        drain();

        repeat (100) @(negedge clk);
        if (expected_results.size() != 0)
            report_mismatch($sformatf("%0d expected results never arrived",
                                      expected_results.size()));
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

`default_nettype wire
